/* hdl/u8v_pkg.sv */
// UTF-8 stream validator package: word types, status codes, state record
// and the small helper functions used by the decode stage.
// No dependencies.
package u8v_pkg;

   localparam int unsigned ScalarWidth = 21;

   typedef logic [2:0] status_type;

   localparam status_type StOk       = 3'd0;
   localparam status_type StControl  = 3'd1;
   localparam status_type StBadLead  = 3'd2;
   localparam status_type StBadCont  = 3'd3;
   localparam status_type StBadScal  = 3'd4;

   localparam logic [7:0] LeadTwoLo   = 8'hC2;
   localparam logic [7:0] LeadTwoHi   = 8'hDF;
   localparam logic [7:0] LeadThreeLo = 8'hE0;
   localparam logic [7:0] LeadThreeHi = 8'hEF;
   localparam logic [7:0] LeadFourLo  = 8'hF0;
   localparam logic [7:0] LeadFourHi  = 8'hF4;
   localparam logic [7:0] AsciiLimit  = 8'h80;

   localparam logic [ScalarWidth-1:0] MinTwo        = 21'h00080;
   localparam logic [ScalarWidth-1:0] MinThree      = 21'h00800;
   localparam logic [ScalarWidth-1:0] MinFour       = 21'h10000;
   localparam logic [ScalarWidth-1:0] ScalarMax     = 21'h10FFFF;
   localparam logic [ScalarWidth-1:0] SurrogateLo   = 21'h0D800;
   localparam logic [ScalarWidth-1:0] SurrogateHi   = 21'h0DFFF;

   typedef struct packed {
      logic [7:0] byte_value;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      status_type                 status;
      logic                       scalar_ready;
      logic [ScalarWidth-1:0]     scalar_value;
      logic                       string_end;
   } rsp_type;

   typedef struct packed {
      logic [1:0]             pending_count;
      logic [ScalarWidth-1:0] partial_scalar;
      logic [1:0]             minimum_class;
      status_type             latched_error;
   } state_type;

   // smallest legal scalar for a sequence of the given class
   function automatic logic [ScalarWidth-1:0] class_minimum(input logic [1:0] cls);
      logic [ScalarWidth-1:0] res;
      unique case (cls)
         2'd1:    res = MinTwo;
         2'd2:    res = MinThree;
         2'd3:    res = MinFour;
         default: res = '0;
      endcase
      return res;
   endfunction

   // NUL and C0 controls other than tab, LF and CR
   function automatic logic is_control(input logic [7:0] c);
      return (c < 8'd32) && (c != 8'h09) && (c != 8'h0A) && (c != 8'h0D);
   endfunction

endpackage

/* hdl/utf8_stream_validator_top.sv */
// UTF-8 stream validator top level: input word register, decode, result
// register and the sequence state. Depends on u8v_pkg and u8v_decode.
// Path: a word accepted into the input register is decoded into the result
//   register and from there shown on rsp_.
// Throughput: one word per cycle when rsp_stall is low; state_ff alone closes the loop.
// Reset: synchronous; empties both registers and clears all sequence state.
module utf8_stream_validator_top (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  u8v_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output u8v_pkg::rsp_type rsp_data
);

   logic               in_valid_ff,  in_valid_in;
   u8v_pkg::req_type   in_data_ff,   in_data_in;
   logic               out_valid_ff, out_valid_in;
   u8v_pkg::rsp_type   out_data_ff,  out_data_in;
   u8v_pkg::state_type state_ff,     state_in;

   u8v_pkg::rsp_type   dec_word;
   u8v_pkg::state_type dec_state;
   logic               out_open;
   logic               in_open;
   logic               dec_fire;

   u8v_decode u_decode (
      .req_word  (in_data_ff),
      .cur_state (state_ff),
      .rsp_word  (dec_word),
      .nxt_state (dec_state)
   );

   assign out_open = !out_valid_ff || !rsp_stall;
   assign in_open  = !in_valid_ff || out_open;
   assign dec_fire = in_valid_ff && out_open;

   always_comb begin
      in_valid_in  = in_open ? req_valid : in_valid_ff;
      in_data_in   = (in_open && req_valid) ? req_data : in_data_ff;
      out_valid_in = out_open ? in_valid_ff : out_valid_ff;
      out_data_in  = dec_fire ? dec_word : out_data_ff;
      // advance the state only when the decoded word moves on
      state_in     = dec_fire ? dec_state : state_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         state_ff     <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      in_data_ff  <= in_data_in;
      out_data_ff <= out_data_in;
   end

   assign req_stall = !in_open;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   a_end_clears: assert property (@(posedge clock) disable iff (reset)
      (dec_fire && in_data_ff.last_byte) |=> (state_ff == '0))
      else $error("state not cleared after string end");

   a_error_sticks: assert property (@(posedge clock) disable iff (reset)
      (state_ff.latched_error != u8v_pkg::StOk && !(dec_fire && in_data_ff.last_byte))
      |=> $stable(state_ff.latched_error))
      else $error("latched error changed before string end");

   a_ready_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.scalar_ready)
      |-> (rsp_data.status == u8v_pkg::StOk && rsp_data.scalar_value <= u8v_pkg::ScalarMax))
      else $error("scalar given with error status or out of range");

   a_no_open_at_end: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.string_end && rsp_data.status == u8v_pkg::StOk)
      |-> (state_ff.pending_count == 2'd0))
      else $error("string ended ok with sequence open");

endmodule

/* hdl/u8v_decode.sv */
// UTF-8 stream validator decode logic: one byte plus the sequence state in,
// the result word and the next sequence state out. Purely combinational.
// Depends on u8v_pkg.
module u8v_decode (
   input  u8v_pkg::req_type   req_word,
   input  u8v_pkg::state_type cur_state,
   output u8v_pkg::rsp_type   rsp_word,
   output u8v_pkg::state_type nxt_state
);

   logic [7:0]                         c;
   logic [u8v_pkg::ScalarWidth-1:0]    cont_scalar;
   logic [1:0]                         pend_dec;
   logic                               scalar_bad;
   u8v_pkg::status_type                status;
   logic                               ready;
   logic [u8v_pkg::ScalarWidth-1:0]    value;

   assign c           = req_word.byte_value;
   assign cont_scalar = {cur_state.partial_scalar[u8v_pkg::ScalarWidth-7:0], c[5:0]};
   assign pend_dec    = cur_state.pending_count - 2'd1;
   assign scalar_bad  = (cont_scalar < u8v_pkg::class_minimum(cur_state.minimum_class))
                     || (cont_scalar > u8v_pkg::ScalarMax)
                     || ((cont_scalar >= u8v_pkg::SurrogateLo)
                         && (cont_scalar <= u8v_pkg::SurrogateHi));

   always_comb begin
      nxt_state = cur_state;
      status    = u8v_pkg::StOk;
      ready     = 1'b0;
      value     = '0;

      if (cur_state.latched_error != u8v_pkg::StOk) begin
         status = cur_state.latched_error;
      end else if (cur_state.pending_count == 2'd0) begin
         priority if (u8v_pkg::is_control(c)) begin
            status = u8v_pkg::StControl;
         end else if (c < u8v_pkg::AsciiLimit) begin
            ready = 1'b1;
            value = {{(u8v_pkg::ScalarWidth-8){1'b0}}, c};
         end else if (c >= u8v_pkg::LeadTwoLo && c <= u8v_pkg::LeadTwoHi) begin
            nxt_state.pending_count  = 2'd1;
            nxt_state.partial_scalar = {{(u8v_pkg::ScalarWidth-5){1'b0}}, c[4:0]};
            nxt_state.minimum_class  = 2'd1;
         end else if (c >= u8v_pkg::LeadThreeLo && c <= u8v_pkg::LeadThreeHi) begin
            nxt_state.pending_count  = 2'd2;
            nxt_state.partial_scalar = {{(u8v_pkg::ScalarWidth-4){1'b0}}, c[3:0]};
            nxt_state.minimum_class  = 2'd2;
         end else if (c >= u8v_pkg::LeadFourLo && c <= u8v_pkg::LeadFourHi) begin
            nxt_state.pending_count  = 2'd3;
            nxt_state.partial_scalar = {{(u8v_pkg::ScalarWidth-3){1'b0}}, c[2:0]};
            nxt_state.minimum_class  = 2'd3;
         end else begin
            status = u8v_pkg::StBadLead;
         end
      end else if (c[7:6] != 2'b10) begin
         status = u8v_pkg::StBadCont;
      end else begin
         nxt_state.partial_scalar = cont_scalar;
         nxt_state.pending_count  = pend_dec;
         if (pend_dec == 2'd0) begin
            if (scalar_bad) begin
               status = u8v_pkg::StBadScal;
            end else begin
               ready = 1'b1;
               value = cont_scalar;
            end
            nxt_state.partial_scalar = '0;
            nxt_state.minimum_class  = 2'd0;
         end
      end

      // string ends with a sequence still open
      if (cur_state.latched_error == u8v_pkg::StOk && status == u8v_pkg::StOk
          && req_word.last_byte && nxt_state.pending_count != 2'd0) begin
         status = u8v_pkg::StBadCont;
      end

      // latch the first error and drop the scalar
      if (cur_state.latched_error == u8v_pkg::StOk && status != u8v_pkg::StOk) begin
         nxt_state.latched_error = status;
         ready = 1'b0;
         value = '0;
      end

      if (req_word.last_byte) begin
         nxt_state = '0;
      end
   end

   assign rsp_word.status       = status;
   assign rsp_word.scalar_ready = ready;
   assign rsp_word.scalar_value = value;
   assign rsp_word.string_end   = req_word.last_byte;

endmodule

/* tb/sv/utf8_result_checker.sv */
// Result checker for the UTF-8 stream validator: watches both channels, predicts
// each byte's status and decoded scalar, and compares every result in order.
// Depends on u8v_pkg for the word types and status codes.
`timescale 1ns / 1ps

module utf8_result_checker (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_stall,
   input  u8v_pkg::req_type req_data,
   input  logic             rsp_valid,
   input  logic             rsp_stall,
   input  u8v_pkg::rsp_type rsp_data,
   output int unsigned      mismatch_count,
   output int unsigned      in_flight,
   output int unsigned      checked_count
);

   // lead class of an open sequence
   localparam logic [1:0] ClassNone  = 2'd0;
   localparam logic [1:0] ClassTwo   = 2'd1;
   localparam logic [1:0] ClassThree = 2'd2;
   localparam logic [1:0] ClassFour  = 2'd3;

   logic [1:0]                      cont_left;
   logic [u8v_pkg::ScalarWidth-1:0] scalar_acc;
   logic [1:0]                      lead_class;
   u8v_pkg::status_type             sticky_status;

   u8v_pkg::rsp_type verdict_q[$];

   initial begin
      mismatch_count = 0;
      in_flight      = 0;
      checked_count  = 0;
   end

   task automatic report_mismatch(input string what, input int unsigned want,
                                  input int unsigned got);
      mismatch_count++;
      $display("[%0t] result %0d: %s expected 0x%0h, got 0x%0h",
               $realtime, checked_count, what, want, got);
   endtask

   // advance the sequence state by one byte and build the result it causes
   task automatic decode_byte(input u8v_pkg::req_type w, output u8v_pkg::rsp_type r);
      logic [7:0]                      c;
      logic [u8v_pkg::ScalarWidth-1:0] floor_val;
      u8v_pkg::status_type             st;
      logic                            ready;
      logic [u8v_pkg::ScalarWidth-1:0] value;
      c     = w.byte_value;
      st    = u8v_pkg::StOk;
      ready = 1'b0;
      value = '0;
      if (sticky_status != u8v_pkg::StOk) begin
         st = sticky_status;
      end else if (cont_left == 2'd0) begin
         if (c < 8'h20 && c != 8'h09 && c != 8'h0A && c != 8'h0D) begin
            st = u8v_pkg::StControl;
         end else if (c < u8v_pkg::AsciiLimit) begin
            ready = 1'b1;
            value = {13'd0, c};
         end else if (c >= u8v_pkg::LeadTwoLo && c <= u8v_pkg::LeadTwoHi) begin
            cont_left  = 2'd1;
            scalar_acc = {16'd0, c[4:0]};
            lead_class = ClassTwo;
         end else if (c >= u8v_pkg::LeadThreeLo && c <= u8v_pkg::LeadThreeHi) begin
            cont_left  = 2'd2;
            scalar_acc = {17'd0, c[3:0]};
            lead_class = ClassThree;
         end else if (c >= u8v_pkg::LeadFourLo && c <= u8v_pkg::LeadFourHi) begin
            cont_left  = 2'd3;
            scalar_acc = {18'd0, c[2:0]};
            lead_class = ClassFour;
         end else begin
            st = u8v_pkg::StBadLead;
         end
      end else if (c[7:6] != 2'b10) begin
         st = u8v_pkg::StBadCont;
      end else begin
         scalar_acc = {scalar_acc[14:0], c[5:0]};
         cont_left  = cont_left - 2'd1;
         if (cont_left == 2'd0) begin
            unique case (lead_class)
               ClassTwo:   floor_val = u8v_pkg::MinTwo;
               ClassThree: floor_val = u8v_pkg::MinThree;
               ClassFour:  floor_val = u8v_pkg::MinFour;
               default:    floor_val = '0;
            endcase
            if (scalar_acc < floor_val || scalar_acc > u8v_pkg::ScalarMax ||
                (scalar_acc >= u8v_pkg::SurrogateLo && scalar_acc <= u8v_pkg::SurrogateHi))
            begin
               st = u8v_pkg::StBadScal;
            end else begin
               ready = 1'b1;
               value = scalar_acc;
            end
            scalar_acc = '0;
            lead_class = ClassNone;
         end
      end
      // string ends with a sequence still open
      if (sticky_status == u8v_pkg::StOk && st == u8v_pkg::StOk && w.last_byte
          && cont_left != 2'd0)
         st = u8v_pkg::StBadCont;
      if (sticky_status == u8v_pkg::StOk && st != u8v_pkg::StOk) begin
         sticky_status = st;
         ready         = 1'b0;
         value         = '0;
      end
      r.status       = st;
      r.scalar_ready = ready;
      r.scalar_value = value;
      r.string_end   = w.last_byte;
      if (w.last_byte) begin
         cont_left     = 2'd0;
         scalar_acc    = '0;
         lead_class    = ClassNone;
         sticky_status = u8v_pkg::StOk;
      end
   endtask

   always @(posedge clock) begin : watch
      u8v_pkg::rsp_type want;
      if (reset) begin
         cont_left     = 2'd0;
         scalar_acc    = '0;
         lead_class    = ClassNone;
         sticky_status = u8v_pkg::StOk;
         verdict_q.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            checked_count++;
            if (verdict_q.size() == 0) begin
               report_mismatch("result with nothing pending", 0, 32'(rsp_data));
            end else begin
               want = verdict_q.pop_front();
               if (rsp_data.status != want.status)
                  report_mismatch("status", 32'(want.status), 32'(rsp_data.status));
               if (rsp_data.scalar_ready != want.scalar_ready)
                  report_mismatch("scalar_ready", 32'(want.scalar_ready),
                                  32'(rsp_data.scalar_ready));
               if (rsp_data.scalar_value != want.scalar_value)
                  report_mismatch("scalar_value", 32'(want.scalar_value),
                                  32'(rsp_data.scalar_value));
               if (rsp_data.string_end != want.string_end)
                  report_mismatch("string_end", 32'(want.string_end),
                                  32'(rsp_data.string_end));
            end
         end
         if (req_valid && !req_stall) begin
            decode_byte(req_data, want);
            verdict_q.push_back(want);
         end
      end
      in_flight = verdict_q.size();
   end

endmodule

/* tb/sv/testbench.sv */
// Top of the UTF-8 stream validator testbench: clock, reset, byte-string
// stimulus under changing idle patterns, and the final verdict.
// Depends on u8v_pkg, utf8_stream_validator_top and utf8_result_checker.
`timescale 1ns / 1ps

module testbench;

   localparam int unsigned RandomWords = 950;
   localparam int unsigned PhaseWords  = 240;
   localparam int unsigned CycleLimit  = 400000;

   typedef logic [7:0] byte_q_type [$];

   logic             clock     = 1'b0;
   logic             reset     = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   u8v_pkg::req_type req_data  = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   u8v_pkg::rsp_type rsp_data;

   int unsigned mismatch_count;
   int unsigned in_flight;
   int unsigned checked_count;

   // idle percentages per phase: none, sender, receiver, both
   int unsigned send_gap_by_phase [4] = '{0, 75, 0, 8};
   int unsigned stall_by_phase    [4] = '{0, 0, 75, 8};

   int unsigned send_idle_pct = 0;
   int unsigned stall_pct     = 0;
   int unsigned words_sent    = 0;
   int unsigned strings_sent  = 0;
   int unsigned cycle_count   = 0;
   byte_q_type  text;

   utf8_stream_validator_top uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   utf8_result_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_data       (rsp_data),
      .mismatch_count (mismatch_count),
      .in_flight      (in_flight),
      .checked_count  (checked_count)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("utf8_stream_validator_top: mismatch");
         $finish;
      end
   end

   // present one word at a falling edge and hold it until it is taken
   task automatic send_word(input logic [7:0] b, input logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{byte_value: b, last_byte: last};
      words_sent++;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic send_text();
      for (int i = 0; i < text.size(); i++) begin
         send_word(text[i], i == text.size() - 1);
      end
      strings_sent++;
   endtask

   initial begin : stimulus
      int unsigned random_words;
      int unsigned phase;
      int unsigned scalars;
      int unsigned kind;
      int unsigned len;
      logic [20:0] v;
      random_words = 0;
      repeat (9) @(negedge clock);
      reset <= 1'b0;

      // directed strings
      text = '{8'h09, 8'h0A, 8'h0D, 8'h7F};
      send_text();
      text = '{8'h00};
      send_text();
      text = '{8'hC2, 8'h80, 8'hF4, 8'h8F, 8'hBF, 8'hBF};
      send_text();
      // bad lead, then the error stays latched
      text = '{8'hFF, 8'h41};
      send_text();
      // control byte where a continuation belongs
      text = '{8'hE0, 8'h1F};
      send_text();
      // surrogate
      text = '{8'hED, 8'hA0, 8'h80};
      send_text();
      // overlong four-byte form
      text = '{8'hF0, 8'h8F, 8'hBF, 8'hBF};
      send_text();
      // truncated sequence
      text = '{8'hE2, 8'h82};
      send_text();

      while (random_words < RandomWords) begin
         phase = (random_words / PhaseWords) % 4;
         send_idle_pct = send_gap_by_phase[phase];
         stall_pct    <= stall_by_phase[phase];
         text.delete();
         scalars = $urandom_range(1, 10);
         repeat (scalars) begin
            kind = $urandom_range(99);
            if (kind < 30) begin
               len = 1;
               if ($urandom_range(9) == 0)
                  v = (kind % 3 == 0) ? 21'h09 : (kind % 3 == 1) ? 21'h0A : 21'h0D;
               else
                  v = 21'($urandom_range(32, 127));
            end else if (kind < 50) begin
               len = 2;
               v   = 21'($urandom_range(21'h80, 21'h7FF));
            end else if (kind < 70) begin
               len = 3;
               v   = 21'($urandom_range(21'h800, 21'hFFFF));
            end else if (kind < 85) begin
               len = 4;
               v   = 21'($urandom_range(21'h10000, 21'h10FFFF));
            end else begin
               // raw fields: overlong forms, stray bytes, out-of-range scalars
               len = $urandom_range(1, 4);
               v   = 21'($urandom());
            end
            case (len)
               1: text.push_back(v[7:0]);
               2: begin
                  text.push_back({3'b110, v[10:6]});
                  text.push_back({2'b10, v[5:0]});
               end
               3: begin
                  text.push_back({4'b1110, v[15:12]});
                  text.push_back({2'b10, v[11:6]});
                  text.push_back({2'b10, v[5:0]});
               end
               default: begin
                  text.push_back({5'b11110, v[20:18]});
                  text.push_back({2'b10, v[17:12]});
                  text.push_back({2'b10, v[11:6]});
                  text.push_back({2'b10, v[5:0]});
               end
            endcase
         end
         if ($urandom_range(99) < 6)
            text[$urandom_range(0, text.size() - 1)] = 8'($urandom_range(0, 255));
         // drop the tail to cut a sequence short
         if ($urandom_range(99) < 6 && text.size() > 1)
            void'(text.pop_back());
         send_text();
         random_words += text.size();
      end

      req_valid <= 1'b0;
      while (in_flight != 0) @(negedge clock);
      repeat (4) @(negedge clock);

      $display("drove %0d bytes in %0d strings under four idle patterns", words_sent,
               strings_sent);
      $display("compared %0d results, %0d field mismatches", checked_count,
               mismatch_count);
      if (mismatch_count == 0) begin
         $display("utf8_stream_validator_top: match");
      end else begin
         $display("utf8_stream_validator_top: mismatch");
      end
      $finish;
   end

endmodule
